// ===== sv/ace_pkg.sv =====
// Shared types, constants and codes of the alarm counter engine.
package ace_pkg;

  localparam int ALARM_SLOTS = 8;
  localparam int AIW        = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int CNT_W      = 16;
  localparam int DVD_W      = CNT_W + 1;
  localparam int STEP_W     = $clog2(DVD_W + 1);
  localparam int QDEPTH     = 2;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CNT_W-1:0] MODULUS_RESET     = 16'd10000;
  localparam logic [CNT_W-1:0] LEAST_CYCLE_RESET = 16'd1;
  localparam logic [CNT_W-1:0] MODULUS_FLOOR     = 16'd2;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SET_REL = 2'd1,
    CMD_SET_ABS = 2'd2,
    CMD_CANCEL  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_BAD_VALUE = 2'd2,
    ST_NOT_BOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_MODULUS     = 2'd0,
    CFG_LEAST_CYCLE = 2'd1,
    CFG_ATTACHED    = 2'd2
  } cfg_idx_e;

  // Work kinds handed from the front to the back
  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET_REL,
    OP_SET_ABS,
    OP_CANCEL,
    OP_REPORT
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_DIV,
    S_SCAN,
    S_WALK,
    S_RELOAD_DIV,
    S_SET_DIV,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]       mod_eff;
    logic [CNT_W-1:0]       least_cycle;
    logic [ALARM_SLOTS-1:0] attached;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [AIW-1:0]   idx;
    logic [CNT_W-1:0] arg;
    logic [CNT_W-1:0] cyc;
    status_e          status;
  } qent_t;

endpackage

// ===== sv/ace_rem.sv =====
// Bit-serial remainder unit: one dividend bit per cycle.
module ace_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ace_pkg::DVD_W-1:0]  dividend_i,
  input  logic [ace_pkg::CNT_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [ace_pkg::CNT_W-1:0]  rem_o
);
  import ace_pkg::*;

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [DVD_W-1:0]  trial;

  assign done_o = busy_q && (cnt_q == '0);
  assign rem_o  = rem_q;
  assign trial  = {rem_q, dvd_q[DVD_W-1]};

  // Load the operands on start, then shift in the next bit and subtract the divisor when it fits
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(DVD_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - STEP_W'(1);
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
        if (trial >= {1'b0, div_q}) begin
          rem_d = CNT_W'(trial - {1'b0, div_q});
        end else begin
          rem_d = trial[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

endmodule

// ===== sv/ace_front.sv =====
// Front end: accepts commands, checks them and queues them for the back end.
module ace_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ace_pkg::cfg_t                   cfg_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: alarm_index[3:0], start_or_offset[19:4], cycle_ticks[35:20], zero fill
  input  logic [ace_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            q_valid_o,
  output ace_pkg::qent_t                  q_entry_o,
  input  logic                            q_pop_i
);
  import ace_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  cmd_e             cmd;
  logic [3:0]       index_raw;
  logic [AIW-1:0]   idx;
  logic [CNT_W-1:0] arg;
  logic [CNT_W-1:0] cyc;
  qent_t            ent;
  logic             push;

  qent_t          mem_q [QDEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]    cnt_q, cnt_d;

  assign cmd       = cmd_e'(s_axis_tuser);
  assign index_raw = s_axis_tdata[3:0];
  assign idx       = index_raw[AIW-1:0];
  assign arg       = s_axis_tdata[19:4];
  assign cyc       = s_axis_tdata[35:20];

  // Classify the command
  always_comb begin
    ent.idx    = idx;
    ent.arg    = arg;
    ent.cyc    = cyc;
    ent.status = ST_OK;
    ent.op     = OP_REPORT;
    case (cmd)
      CMD_TICK: begin
        ent.op = OP_TICK;
      end
      default: begin
        if (index_raw >= 4'(ALARM_SLOTS)) begin
          ent.status = ST_BAD_INDEX;
        end else if (cmd == CMD_CANCEL) begin
          ent.op = OP_CANCEL;
        end else if (cmd == CMD_SET_REL && arg == '0) begin
          ent.status = ST_BAD_VALUE;
        end else if (!cfg_i.attached[idx]) begin
          ent.status = ST_NOT_BOUND;
        end else if (cyc != '0 && cyc < cfg_i.least_cycle) begin
          ent.status = ST_BAD_VALUE;
        end else if (cmd == CMD_SET_REL) begin
          ent.op = OP_SET_REL;
        end else begin
          ent.op = OP_SET_ABS;
        end
      end
    endcase
  end

  // Two-entry queue between front and back
  assign s_axis_tready = (cnt_q != (PW+1)'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign q_entry_o     = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(QDEPTH-1)) ? '0 : wr_q + PW'(1);
    end
    if (q_pop_i) begin
      rd_d = (rd_q == PW'(QDEPTH-1)) ? '0 : rd_q + PW'(1);
    end
    case ({push, q_pop_i})
      2'b10:   cnt_d = cnt_q + (PW+1)'(1);
      2'b01:   cnt_d = cnt_q - (PW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= ent;
    end
  end

endmodule

// ===== sv/ace_back.sv =====
// Back end: runs queued commands against the counter and alarm table.
module ace_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ace_pkg::cfg_t                    cfg_i,
  input  logic                             q_valid_i,
  input  ace_pkg::qent_t                   q_entry_i,
  output logic                             q_pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: status[1:0], fired_alarm[4:2], counter_now[20:5], zero fill
  output logic [ace_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // tuser: fired
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);
  import ace_pkg::*;

  function automatic logic [AIW-1:0] lowest_set(input logic [ALARM_SLOTS-1:0] v);
    logic [AIW-1:0] r;
    r = '0;
    for (int i = ALARM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = AIW'(i);
    end
    return r;
  endfunction

  state_e state_q, state_d;

  op_e              op_q;
  logic [AIW-1:0]   idx_q;
  logic [CNT_W-1:0] cyc_q;
  logic [CNT_W-1:0] counter_q;

  logic             active_q [ALARM_SLOTS];
  logic [CNT_W-1:0] expiry_q [ALARM_SLOTS];
  logic [CNT_W-1:0] reload_q [ALARM_SLOTS];

  logic [ALARM_SLOTS-1:0] mask_q, match;
  logic [AIW-1:0]         sel, sel_q;
  logic [ALARM_SLOTS-1:0] mask_rest;

  status_e          res_status_q;
  logic             res_fired_q, res_last_q;
  logic [AIW-1:0]   res_alarm_q;

  logic             out_valid_q;
  logic [2:0]       out_alarm_q;
  status_e          out_status_q;
  logic [CNT_W-1:0] out_count_q;
  logic             out_fired_q, out_last_q;
  logic             out_free, out_load;

  logic             rem_start, rem_done;
  logic [DVD_W-1:0] rem_dvd;
  logic [CNT_W-1:0] rem_val;

  ace_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .divisor_i  (cfg_i.mod_eff),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // Compare every bound, active alarm against the new count
  always_comb begin
    for (int i = 0; i < ALARM_SLOTS; i++) begin
      match[i] = active_q[i] && cfg_i.attached[i] && (expiry_q[i] == counter_q);
    end
  end

  assign sel       = lowest_set(mask_q);
  assign mask_rest = mask_q & ~(ALARM_SLOTS'(1) << sel);
  assign out_free  = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.op)
            OP_TICK:    state_d = S_TICK_DIV;
            OP_SET_REL: state_d = S_SET_DIV;
            OP_SET_ABS: state_d = S_SET_DIV;
            default:    state_d = S_EMIT;
          endcase
        end
      end
      S_TICK_DIV:   if (rem_done) state_d = S_SCAN;
      S_SCAN:       state_d = (match == '0) ? S_EMIT : S_WALK;
      S_WALK:       state_d = (reload_q[sel] != '0) ? S_RELOAD_DIV : S_EMIT;
      S_RELOAD_DIV: if (rem_done) state_d = S_EMIT;
      S_SET_DIV:    if (rem_done) state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = (op_q == OP_TICK && mask_q != '0) ? S_WALK : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop_o   = 1'b0;
    rem_start = 1'b0;
    rem_dvd   = {1'b0, counter_q} + DVD_W'(1);
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        q_pop_o = q_valid_i;
        case (q_entry_i.op)
          OP_TICK: begin
            rem_start = q_valid_i;
          end
          OP_SET_REL: begin
            rem_start = q_valid_i;
            rem_dvd   = {1'b0, counter_q} + {1'b0, q_entry_i.arg};
          end
          OP_SET_ABS: begin
            rem_start = q_valid_i;
            rem_dvd   = {1'b0, q_entry_i.arg};
          end
          default: rem_start = 1'b0;
        endcase
      end
      S_WALK: begin
        rem_start = (reload_q[sel] != '0);
        rem_dvd   = {1'b0, counter_q} + {1'b0, reload_q[sel]};
      end
      S_EMIT: begin
        out_load = out_free;
      end
      default: q_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q <= '0;
    end else if (state_q == S_TICK_DIV && rem_done) begin
      counter_q <= rem_val;
    end
  end

  // Update active flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALARM_SLOTS; i++) active_q[i] <= 1'b0;
    end else begin
      if (state_q == S_IDLE && q_valid_i && q_entry_i.op == OP_CANCEL) begin
        active_q[q_entry_i.idx] <= 1'b0;
      end
      if (state_q == S_WALK && reload_q[sel] == '0) begin
        active_q[sel] <= 1'b0;
      end
      if (state_q == S_SET_DIV && rem_done) begin
        active_q[idx_q] <= 1'b1;
      end
    end
  end

  // Write expiry and reload entries
  always_ff @(posedge clk_i) begin
    if (state_q == S_SET_DIV && rem_done) begin
      expiry_q[idx_q] <= rem_val;
      reload_q[idx_q] <= cyc_q;
    end
    if (state_q == S_RELOAD_DIV && rem_done) begin
      expiry_q[sel_q] <= rem_val;
    end
  end

  // Capture the command and build the pending result
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) begin
      op_q         <= q_entry_i.op;
      idx_q        <= q_entry_i.idx;
      cyc_q        <= q_entry_i.cyc;
      res_status_q <= q_entry_i.status;
      res_fired_q  <= 1'b0;
      res_alarm_q  <= '0;
      res_last_q   <= 1'b1;
      mask_q       <= '0;
    end
    if (state_q == S_SCAN) begin
      mask_q <= match;
    end
    if (state_q == S_WALK) begin
      sel_q       <= sel;
      mask_q      <= mask_rest;
      res_fired_q <= 1'b1;
      res_alarm_q <= sel;
      res_last_q  <= (mask_rest == '0);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_fired_q  <= res_fired_q;
      out_alarm_q  <= 3'(res_alarm_q);
      out_count_q  <= counter_q;
      out_last_q   <= res_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_alarm_q, out_status_q};
  assign m_axis_tuser  = out_fired_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== sv/alarm_counter_engine.sv =====
// Top level of the alarm counter engine: config registers, front end, queue and back end.
// Path to the result register: a rejected set or a cancel goes straight to emit; a valid set
// first runs the remainder unit; a tick runs it, then scans for matches. Each fired alarm is
// then walked and emitted, with one more remainder run for a reload (single shot needs none).
// One command is in the back end at a time; a 2-entry queue takes new commands.
// Reset: asynchronous active low; clears counter, active flags, queue and config to defaults.
module alarm_counter_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ace_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ace_pkg::CNT_W-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: alarm_index[3:0], start_or_offset[19:4], cycle_ticks[35:20], zero fill
  input  logic [ace_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: status[1:0], fired_alarm[4:2], counter_now[20:5], zero fill
  output logic [ace_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: fired
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import ace_pkg::*;

  logic [CNT_W-1:0]       modulus_q;
  logic [CNT_W-1:0]       least_cycle_q;
  logic [ALARM_SLOTS-1:0] attached_q;
  cfg_t                   cfg;
  logic                   q_valid, q_pop;
  qent_t                  q_entry;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q     <= MODULUS_RESET;
      least_cycle_q <= LEAST_CYCLE_RESET;
      attached_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODULUS:     modulus_q     <= cfg_data_i;
        CFG_LEAST_CYCLE: least_cycle_q <= cfg_data_i;
        CFG_ATTACHED:    attached_q    <= cfg_data_i[ALARM_SLOTS-1:0];
        default:         modulus_q     <= modulus_q;
      endcase
    end
  end

  // Clamp the modulus to at least two
  assign cfg.mod_eff     = (modulus_q < MODULUS_FLOOR) ? MODULUS_FLOOR : modulus_q;
  assign cfg.least_cycle = least_cycle_q;
  assign cfg.attached    = attached_q;

  ace_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_entry_o     (q_entry),
    .q_pop_i       (q_pop)
  );

  ace_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // A fired result always reports status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == ST_OK)
    else $error("fired result with nonzero status");

  // A fired result names an existing alarm
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> {1'b0, m_axis_tdata[4:2]} < 4'(ALARM_SLOTS))
    else $error("fired alarm index out of range");

  // A result that reports no expiry is the only one of its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("non-fired result not marked last");

  // The queue is never popped while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule
